### sv/aabbcr_pkg.sv
package aabbcr_pkg;

    localparam int COORD_W = 20;
    localparam int EXT_W   = 23;
    localparam int CFG_W   = 16;
    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam logic [1:0] OP_PLACE    = 2'd0;
    localparam logic [1:0] OP_RESOLVE_H = 2'd1;
    localparam logic [1:0] OP_RESOLVE_V = 2'd2;

    localparam logic [1:0] REG_BLOCK_WIDTH  = 2'd0;
    localparam logic [1:0] REG_BLOCK_HEIGHT = 2'd1;
    localparam logic [1:0] REG_MOVER_WIDTH  = 2'd2;
    localparam logic [1:0] REG_MOVER_HEIGHT = 2'd3;

    localparam logic [CFG_W-1:0] BLOCK_WIDTH_RST  = 16'd400;
    localparam logic [CFG_W-1:0] BLOCK_HEIGHT_RST = 16'd800;
    localparam logic [CFG_W-1:0] MOVER_WIDTH_RST  = 16'd0;
    localparam logic [CFG_W-1:0] MOVER_HEIGHT_RST = 16'd0;

    localparam logic signed [EXT_W-1:0] COORD_MAX_EXT = 23'sd524287;
    localparam logic signed [EXT_W-1:0] COORD_MIN_EXT = -23'sd524288;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [EXT_W-1:0]   t_ext;

    typedef struct packed {
        t_coord x;
        t_coord y;
    } t_block;

    function automatic t_ext ext_coord(input t_coord v);
        return {{(EXT_W-COORD_W){v[COORD_W-1]}}, v};
    endfunction

    // zero-extended half or full size
    function automatic t_ext ext_size(input logic [CFG_W-1:0] v);
        return {{(EXT_W-CFG_W){1'b0}}, v};
    endfunction

    function automatic t_coord sat_coord(input t_ext v);
        t_coord r;
        if (v > COORD_MAX_EXT) begin
            r = COORD_MAX_EXT[COORD_W-1:0];
        end else if (v < COORD_MIN_EXT) begin
            r = COORD_MIN_EXT[COORD_W-1:0];
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

### sv/aabb_block_collision_resolver.sv
// place item and unused operation code: the accepted item goes to the finish state, and its
// result is then loaded into the output register; resolve item: the walk state reads every
// placed block, one block per cycle through the single read port of the block memory
// throughput: one item at a time, the input stalls until the result is loaded into the
// output register, which waits while an earlier result is still stalled
// reset (synchronous, active low) empties the table through its fill count, loads defaults
module aabb_block_collision_resolver #(
    parameter int NUM_BLOCKS = 64
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [1:0]                    i_operation,
    input  aabbcr_pkg::t_coord            i_pos_x,
    input  aabbcr_pkg::t_coord            i_pos_y,
    input  aabbcr_pkg::t_coord            i_old_x,
    input  aabbcr_pkg::t_coord            i_old_y,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output aabbcr_pkg::t_coord            o_new_x,
    output aabbcr_pkg::t_coord            o_new_y,
    output logic                          o_stop_motion,
    output logic                          o_landed,
    output logic                          o_placed,
    output logic                          o_table_full,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [aabbcr_pkg::PADDR_W-1:0] paddr,
    input  logic [aabbcr_pkg::PDATA_W-1:0] pwdata,
    output logic [aabbcr_pkg::PDATA_W-1:0] prdata,
    output logic                          pready
);
    import aabbcr_pkg::*;

    localparam int AW = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
    localparam int CW = $clog2(NUM_BLOCKS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_WALK,
        S_FINISH
    } t_state;

    t_state r_state;

    logic [CFG_W-1:0] r_block_width;
    logic [CFG_W-1:0] r_block_height;
    logic [CFG_W-1:0] r_mover_width;
    logic [CFG_W-1:0] r_mover_height;

    // blocks are never removed, so the valid entries are exactly those below the fill count
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_idx;
    logic          r_pend;

    t_block r_mem [NUM_BLOCKS];
    t_block r_rdata;

    logic [1:0] r_op;
    t_coord     r_x;
    t_coord     r_y;
    t_coord     r_ox;
    t_coord     r_oy;
    logic       r_stop;
    logic       r_landed;
    logic       r_placed;
    logic       r_full;

    logic   r_out_valid;
    t_coord r_out_x;
    t_coord r_out_y;
    logic   r_out_stop;
    logic   r_out_landed;
    logic   r_out_placed;
    logic   r_out_full;

    t_coord n_x;
    t_coord n_y;
    logic   n_stop;
    logic   n_landed;

    logic              w_accept;
    logic              w_has_room;
    logic              w_mem_we;
    logic              w_cfg_we;
    logic              w_out_load;
    logic [CFG_W-1:0]  w_rd_reg;

    assign o_in_stall = (r_state != S_IDLE);
    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_has_room = (r_count < CW'(NUM_BLOCKS));
    assign w_mem_we   = w_accept && (i_operation == OP_PLACE) && w_has_room;
    assign pready     = 1'b1;
    assign w_cfg_we   = psel && penable && pwrite && pready;
    assign w_out_load = (r_state == S_FINISH) && (!r_out_valid || !i_out_stall);

    always_comb begin
        case (paddr[3:2])
            REG_BLOCK_WIDTH:  w_rd_reg = r_block_width;
            REG_BLOCK_HEIGHT: w_rd_reg = r_block_height;
            REG_MOVER_WIDTH:  w_rd_reg = r_mover_width;
            REG_MOVER_HEIGHT: w_rd_reg = r_mover_height;
            default:          w_rd_reg = '0;
        endcase
    end

    assign prdata = {{(PDATA_W-CFG_W){1'b0}}, w_rd_reg};

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[r_count[AW-1:0]] <= '{x: i_pos_x, y: i_pos_y};
        end
        r_rdata <= r_mem[r_idx[AW-1:0]];
    end

    // one block against the carried position
    always_comb begin
        t_ext bx, by, bw2, bht, mw2, mh, x, y, ox, oy;
        t_ext b_left, b_right, b_bottom;
        logic v_ovl, h_ovl, hit_left, hit_right, hit_top, hit_bottom;
        bx  = ext_coord(r_rdata.x);
        by  = ext_coord(r_rdata.y);
        bw2 = ext_size({1'b0, r_block_width[CFG_W-1:1]});
        bht = ext_size(r_block_height);
        mw2 = ext_size({1'b0, r_mover_width[CFG_W-1:1]});
        mh  = ext_size(r_mover_height);
        x   = ext_coord(r_x);
        y   = ext_coord(r_y);
        ox  = ext_coord(r_ox);
        oy  = ext_coord(r_oy);
        b_left   = bx - bw2;
        b_right  = bx + bw2;
        b_bottom = by + bht;

        v_ovl      = (oy > by) && (oy - mh < b_bottom);
        hit_left   = (ox + mw2 <= b_left) && (x + mw2 > b_left);
        hit_right  = (ox - mw2 >= b_right) && (x - mw2 < b_right);
        h_ovl      = (x + mw2 > b_left) && (x - mw2 < b_right);
        hit_top    = (oy <= by) && (y > by);
        hit_bottom = (oy - mh >= b_bottom) && (y - mh < b_bottom);

        n_x      = r_x;
        n_y      = r_y;
        n_stop   = r_stop;
        n_landed = r_landed;
        if (r_op == OP_RESOLVE_H) begin
            // both face tests can only pass with zero sizes, and then the right one
            // fails on the clamped x, so one test per block is enough
            if (v_ovl && hit_left) begin
                n_x    = sat_coord(b_left - mw2);
                n_stop = 1'b1;
            end else if (v_ovl && hit_right) begin
                n_x    = sat_coord(b_right + mw2);
                n_stop = 1'b1;
            end
        end else begin
            if (h_ovl && hit_top) begin
                n_y      = r_rdata.y;
                n_stop   = 1'b1;
                n_landed = 1'b1;
            end else if (h_ovl && hit_bottom) begin
                n_y    = sat_coord(b_bottom + mh);
                n_stop = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_count        <= '0;
            r_idx          <= '0;
            r_pend         <= 1'b0;
            r_out_valid    <= 1'b0;
            r_block_width  <= BLOCK_WIDTH_RST;
            r_block_height <= BLOCK_HEIGHT_RST;
            r_mover_width  <= MOVER_WIDTH_RST;
            r_mover_height <= MOVER_HEIGHT_RST;
        end else begin
            if (w_cfg_we) begin
                case (paddr[3:2])
                    REG_BLOCK_WIDTH:  r_block_width  <= pwdata[CFG_W-1:0];
                    REG_BLOCK_HEIGHT: r_block_height <= pwdata[CFG_W-1:0];
                    REG_MOVER_WIDTH:  r_mover_width  <= pwdata[CFG_W-1:0];
                    REG_MOVER_HEIGHT: r_mover_height <= pwdata[CFG_W-1:0];
                    default: ;
                endcase
            end

            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (r_out_valid && !i_out_stall) begin
                r_out_valid <= 1'b0;
            end

            case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_op     <= i_operation;
                        r_ox     <= i_old_x;
                        r_oy     <= i_old_y;
                        r_idx    <= '0;
                        r_pend   <= 1'b0;
                        r_stop   <= 1'b0;
                        r_landed <= 1'b0;
                        case (i_operation)
                            OP_PLACE: begin
                                r_x      <= '0;
                                r_y      <= '0;
                                r_placed <= w_has_room;
                                r_full   <= !w_has_room;
                                if (w_has_room) begin
                                    r_count <= r_count + CW'(1);
                                end
                                r_state <= S_FINISH;
                            end
                            OP_RESOLVE_H, OP_RESOLVE_V: begin
                                r_x      <= i_pos_x;
                                r_y      <= i_pos_y;
                                r_placed <= 1'b0;
                                r_full   <= 1'b0;
                                r_state  <= S_WALK;
                            end
                            default: begin
                                r_x      <= '0;
                                r_y      <= '0;
                                r_placed <= 1'b0;
                                r_full   <= 1'b0;
                                r_state  <= S_FINISH;
                            end
                        endcase
                    end
                end
                S_WALK: begin
                    r_pend <= (r_idx < r_count);
                    if (r_idx < r_count) begin
                        r_idx <= r_idx + CW'(1);
                    end
                    if (r_pend) begin
                        r_x      <= n_x;
                        r_y      <= n_y;
                        r_stop   <= n_stop;
                        r_landed <= n_landed;
                    end
                    if ((r_idx == r_count) && !r_pend) begin
                        r_state <= S_FINISH;
                    end
                end
                S_FINISH: begin
                    if (w_out_load) begin
                        r_out_x      <= r_x;
                        r_out_y      <= r_y;
                        r_out_stop   <= r_stop;
                        r_out_landed <= r_landed;
                        r_out_placed <= r_placed;
                        r_out_full   <= r_full;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_new_x       = r_out_x;
    assign o_new_y       = r_out_y;
    assign o_stop_motion = r_out_stop;
    assign o_landed      = r_out_landed;
    assign o_placed      = r_out_placed;
    assign o_table_full  = r_out_full;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(NUM_BLOCKS))
        else $error("fill count beyond table depth");

    a_walk_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WALK) |-> (r_idx <= r_count))
        else $error("walk index past fill count");

    a_pend_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pend |-> (r_state == S_WALK))
        else $error("memory read pending outside walk");

    a_landed_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_landed) |-> (o_stop_motion && !o_placed && !o_table_full))
        else $error("landed without stop or with place flags");

    a_place_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_placed && o_table_full))
        else $error("placed and table full together");

endmodule
